@@ hdl/bmsca_pkg.sv @@
// Shared constants and types for the battery cell voltage aggregator.
`default_nettype none
package bmsca_pkg;

	localparam int CELLS    = 24;
	localparam int ROWS     = CELLS / 4;
	localparam int ROW_W    = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int ID_W     = 29;
	localparam int WORD_W   = 16;
	localparam int SUM_W    = 21;
	localparam int QUAD_W   = WORD_W + 2;
	localparam int FIRST_W  = 5;
	localparam int GRP_W    = 6;
	localparam int GRP_BIAS = 9;
	localparam int ODD_ROWS = 3;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [3:0][WORD_W-1:0] quad_t;

	typedef struct packed {
		logic capture;
		logic evaluate;
		logic commit;
	} cmd_t;

endpackage
`default_nettype wire

@@ hdl/bmsca_if.sv @@
// Valid/ready channel interfaces for the frame input and the result output.
`default_nettype none
interface bmsca_in_if;
	logic                                 valid;
	logic                                 ready;
	logic [bmsca_pkg::ID_W-1:0]           frame_id;
	logic [bmsca_pkg::WORD_W-1:0]         cell_word_0;
	logic [bmsca_pkg::WORD_W-1:0]         cell_word_1;
	logic [bmsca_pkg::WORD_W-1:0]         cell_word_2;
	logic [bmsca_pkg::WORD_W-1:0]         cell_word_3;

	modport source (output valid, frame_id, cell_word_0, cell_word_1, cell_word_2,
		cell_word_3, input ready);
	modport sink (input valid, frame_id, cell_word_0, cell_word_1, cell_word_2,
		cell_word_3, output ready);
endinterface

interface bmsca_out_if;
	logic                                 valid;
	logic                                 ready;
	logic [bmsca_pkg::SUM_W-1:0]          series_sum;
	logic                                 all_cells_seen;
	logic                                 index_error;
	logic [bmsca_pkg::FIRST_W-1:0]        first_cell;

	modport source (output valid, series_sum, all_cells_seen, index_error, first_cell,
		input ready);
	modport sink (input valid, series_sum, all_cells_seen, index_error, first_cell,
		output ready);
endinterface
`default_nettype wire

@@ hdl/bms_cell_voltage_aggregator.sv @@
// A frame is handled in steps: capture, read of the old cell group, commit.
// A new frame is not taken before the last one is committed, and the commit waits
// while the previous result has not yet been taken.
// The input is taken again as soon as the result register is loaded.
// Reset clears the cell store, seen map, ready flag and running total at once.
`default_nettype none
module bms_cell_voltage_aggregator (
	input  wire logic  clk,
	input  wire logic  arst_n,
	bmsca_in_if.sink   cell_in,
	bmsca_out_if.source sum_out
);

	bmsca_pkg::cmd_t  cmd;
	bmsca_pkg::quad_t words;

	assign words = {cell_in.cell_word_3, cell_in.cell_word_2,
		cell_in.cell_word_1, cell_in.cell_word_0};

	bmsca_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cell_in.valid),
		.in_ready  (cell_in.ready),
		.out_valid (sum_out.valid),
		.out_ready (sum_out.ready),
		.cmd       (cmd)
	);

	bmsca_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.frame_id       (cell_in.frame_id),
		.words          (words),
		.series_sum     (sum_out.series_sum),
		.all_cells_seen (sum_out.all_cells_seen),
		.index_error    (sum_out.index_error),
		.first_cell     (sum_out.first_cell)
	);

endmodule
`default_nettype wire

@@ hdl/bmsca_ctrl.sv @@
// Sequencer: accept an item, evaluate the old cell group, then commit the result.
`default_nettype none
module bmsca_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output bmsca_pkg::cmd_t      cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_WRITE
	} state_t;

	state_t state_q;
	logic   in_ready_q;
	logic   out_valid_q;

	assign in_ready     = in_ready_q;
	assign out_valid    = out_valid_q;
	assign cmd.capture  = in_valid && in_ready_q;
	assign cmd.evaluate = (state_q == S_READ);
	assign cmd.commit   = (state_q == S_WRITE) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			in_ready_q  <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			// drop the result once taken; a commit below reloads it
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q    <= S_READ;
						in_ready_q <= 1'b0;
					end
				end
				S_READ: begin
					state_q <= S_WRITE;
				end
				S_WRITE: begin
					if (!out_valid_q || out_ready) begin
						state_q     <= S_IDLE;
						in_ready_q  <= 1'b1;
						out_valid_q <= 1'b1;
					end
				end
				default: begin
					state_q    <= S_IDLE;
					in_ready_q <= 1'b1;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

@@ hdl/bmsca_datapath.sv @@
// Cell store, seen map, running total and result registers.
`default_nettype none
module bmsca_datapath (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire bmsca_pkg::cmd_t                 cmd,
	input  wire logic [bmsca_pkg::ID_W-1:0]      frame_id,
	input  wire bmsca_pkg::quad_t                words,
	output logic [bmsca_pkg::SUM_W-1:0]          series_sum,
	output logic                                 all_cells_seen,
	output logic                                 index_error,
	output logic [bmsca_pkg::FIRST_W-1:0]        first_cell
);

	// cell store kept as rows of four: every valid base index is a multiple of four
	bmsca_pkg::quad_t                  store_q [bmsca_pkg::ROWS];
	logic [bmsca_pkg::CELLS-1:0]       seen_q;
	logic                              ready_flag_q;
	logic [bmsca_pkg::SUM_W-1:0]       total_q;

	bmsca_pkg::quad_t                  words_q;
	logic [bmsca_pkg::ROW_W-1:0]       row_q;
	logic                              err_q;
	logic [bmsca_pkg::QUAD_W-1:0]      old_sum_q;
	logic [bmsca_pkg::QUAD_W-1:0]      new_sum_q;
	logic                              index_error_q;
	logic [bmsca_pkg::FIRST_W-1:0]     first_cell_q;

	logic signed [bmsca_pkg::GRP_W-1:0] grp;
	logic                               grp_err;
	bmsca_pkg::quad_t                   old_row;
	logic [bmsca_pkg::QUAD_W-1:0]       old_sum;
	logic [bmsca_pkg::QUAD_W-1:0]       new_sum;
	logic [bmsca_pkg::CELLS-1:0]        row_mask;
	logic [bmsca_pkg::CELLS-1:0]        seen_next;
	logic [bmsca_pkg::SUM_W-1:0]        total_next;

	// row = (id[11:8] - 9) + 3 * id[0]
	always_comb begin
		grp = $signed({2'b00, frame_id[11:8]}) - bmsca_pkg::GRP_W'(bmsca_pkg::GRP_BIAS);
		if (frame_id[0])
			grp = grp + bmsca_pkg::GRP_W'(bmsca_pkg::ODD_ROWS);
		grp_err = (grp < 0) || (grp >= $signed(bmsca_pkg::GRP_W'(bmsca_pkg::ROWS)));
	end

	always_comb begin
		old_row = '0;
		if (!err_q)
			old_row = store_q[row_q];
		old_sum = bmsca_pkg::QUAD_W'(old_row[0]) + bmsca_pkg::QUAD_W'(old_row[1])
			+ bmsca_pkg::QUAD_W'(old_row[2]) + bmsca_pkg::QUAD_W'(old_row[3]);
		new_sum = bmsca_pkg::QUAD_W'(words_q[0]) + bmsca_pkg::QUAD_W'(words_q[1])
			+ bmsca_pkg::QUAD_W'(words_q[2]) + bmsca_pkg::QUAD_W'(words_q[3]);
	end

	always_comb begin
		for (int c = 0; c < bmsca_pkg::CELLS; c++)
			row_mask[c] = (bmsca_pkg::ROW_W'(c / 4) == row_q);
		seen_next  = seen_q | row_mask;
		total_next = total_q + bmsca_pkg::SUM_W'(new_sum_q) - bmsca_pkg::SUM_W'(old_sum_q);
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			words_q <= words;
			row_q   <= grp[bmsca_pkg::ROW_W-1:0];
		end
		if (cmd.evaluate) begin
			old_sum_q <= old_sum;
			new_sum_q <= new_sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < bmsca_pkg::ROWS; r++)
				store_q[r] <= '0;
			seen_q        <= '0;
			ready_flag_q  <= 1'b0;
			total_q       <= '0;
			err_q         <= 1'b0;
			index_error_q <= 1'b0;
			first_cell_q  <= '0;
		end else begin
			if (cmd.capture)
				err_q <= grp_err;
			if (cmd.commit) begin
				index_error_q <= err_q;
				if (err_q) begin
					first_cell_q <= '0;
				end else begin
					store_q[row_q] <= words_q;
					seen_q         <= seen_next;
					total_q        <= total_next;
					first_cell_q   <= bmsca_pkg::FIRST_W'({row_q, 2'b00});
					if (&seen_next)
						ready_flag_q <= 1'b1;
				end
			end
		end
	end

	assign series_sum     = total_q;
	assign all_cells_seen = ready_flag_q;
	assign index_error    = index_error_q;
	assign first_cell     = first_cell_q;

endmodule
`default_nettype wire
